// ----- hdl/ats_pkg.sv -----
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants of the tiled affine texture sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int ACC_W     = 48;   // coordinate accumulator width
    localparam int FRAC_W    = 16;   // fraction bits of the coordinates
    localparam int COEF_W    = 32;   // matrix coefficient width
    localparam int DIM_W     = 8;    // texel column or row width
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int SIZE_W    = DIM_W + 1;
    localparam int MOD_W     = DIM_W + 2;
    localparam int DVD_W     = 32;   // magnitude of a rounded coordinate
    localparam int RADIX_W   = 4;    // quotient bits per divider cycle
    localparam int DIV_CYC   = DVD_W / RADIX_W;
    localparam int DCNT_W    = $clog2(DIV_CYC);
    localparam int CNT_W     = 7;
    localparam int SPAN_MAX  = 64;
    localparam int TEXEL_W   = 32;
    localparam int IN_W      = 88;
    localparam int CFG_W     = 32;
    localparam int CIDX_W    = 3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_M_XX   = 3'd0,
        CFG_M_YX   = 3'd1,
        CFG_M_XY   = 3'd2,
        CFG_M_YY   = 3'd3,
        CFG_M_TX   = 3'd4,
        CFG_M_TY   = 3'd5,
        CFG_TILE   = 3'd6,
        CFG_SIZE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TILE_CLAMP  = 2'd0,
        TILE_REPEAT = 2'd1,
        TILE_MIRROR = 2'd2,
        TILE_SPARE  = 2'd3
    } t_tile;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SPAN = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_FETCH,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic latch;
        logic mul;
        logic sum;
        logic prep;
        logic div;
        logic fetch;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_blocked;
    } t_sts;

endpackage

// ----- hdl/ats_mod.sv -----
// ----------------------------------------------------------------------------
// ats_mod
// Restoring remainder unit, four dividend bits per cycle.
// ----------------------------------------------------------------------------
module ats_mod (
    input  logic                           i_clk,
    input  logic                           i_start,
    input  logic                           i_step,
    input  logic [ats_pkg::DVD_W-1:0]      i_dividend,
    input  logic [ats_pkg::MOD_W-1:0]      i_divisor,
    output logic [ats_pkg::MOD_W-1:0]      o_rem
);

    logic [ats_pkg::DVD_W-1:0] r_q;
    logic [ats_pkg::MOD_W-1:0] r_rem;
    logic [ats_pkg::MOD_W-1:0] r_div;
    logic [ats_pkg::DVD_W-1:0] n_q;
    logic [ats_pkg::MOD_W-1:0] n_rem;

    always_comb begin
        logic [ats_pkg::MOD_W:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < ats_pkg::RADIX_W; k++) begin
            t = {n_rem, n_q[ats_pkg::DVD_W-1]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[ats_pkg::MOD_W-1:0];
            n_q   = {n_q[ats_pkg::DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (i_step) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

// ----- hdl/ats_ctrl.sv -----
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer: texel loads, span set-up, per-pixel divide, fetch and push.
// ----------------------------------------------------------------------------
module ats_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_opcode,
    input  logic           i_count_nz,
    input  ats_pkg::t_sts  i_sts,
    output logic           o_ready,
    output ats_pkg::t_cmd  o_cmd
);

    ats_pkg::t_state r_state, n_state;
    logic [ats_pkg::DCNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ats_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ats_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_opcode == ats_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_count_nz) begin
                        o_cmd.latch = 1'b1;
                        n_state     = ats_pkg::ST_MUL;
                    end
                end
            end
            ats_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ats_pkg::ST_SUM;
            end
            ats_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ats_pkg::ST_PREP;
            end
            ats_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = ats_pkg::ST_DIV;
            end
            ats_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == ats_pkg::DCNT_W'(ats_pkg::DIV_CYC - 1)) begin
                    n_state = ats_pkg::ST_FETCH;
                end
            end
            ats_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ats_pkg::ST_PUSH;
            end
            ats_pkg::ST_PUSH: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_sts.last ? ats_pkg::ST_IDLE : ats_pkg::ST_PREP;
                end
            end
            default: n_state = ats_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/ats_dp.sv -----
// ----------------------------------------------------------------------------
// ats_dp
// Datapath: registers, matrix products, accumulators, tiling, texel store.
// ----------------------------------------------------------------------------
module ats_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ats_pkg::t_cmd                   i_cmd,
    output ats_pkg::t_sts                   o_sts,
    input  logic                            i_cfg_we,
    input  logic [ats_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [ats_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic signed [15:0]              i_dev_x,
    input  logic signed [15:0]              i_dev_y,
    input  logic [ats_pkg::CNT_W-1:0]       i_span_count,
    input  logic [ats_pkg::DIM_W-1:0]       i_tex_col,
    input  logic [ats_pkg::DIM_W-1:0]       i_tex_row,
    input  logic [ats_pkg::TEXEL_W-1:0]     i_texel,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ats_pkg::TEXEL_W-1:0]     o_pixel,
    output logic                            o_last
);

    localparam int P_W = ats_pkg::COEF_W + 17;
    localparam int S_W = P_W + 2;

    logic signed [ats_pkg::COEF_W-1:0] r_m_xx, r_m_yx, r_m_xy, r_m_yy, r_m_tx, r_m_ty;
    logic [1:0]                        r_tile;
    logic [15:0]                       r_size;
    logic signed [16:0]                r_x2, r_y2;
    logic [ats_pkg::CNT_W-1:0]         r_left;
    logic signed [P_W-1:0]             r_p_uxx, r_p_uxy, r_p_vyx, r_p_vyy;
    logic signed [ats_pkg::ACC_W-1:0]  r_u, r_v;
    logic [ats_pkg::TEXEL_W-1:0]       r_mem [0:(1 << ats_pkg::ADDR_W)-1];
    logic [ats_pkg::TEXEL_W-1:0]       r_rd_data;
    logic                              r_rd_last;
    logic                              r_out_valid;
    logic [ats_pkg::TEXEL_W-1:0]       r_out_data;
    logic                              r_out_last;

    logic [ats_pkg::SIZE_W-1:0]        w_sw, w_sh;
    logic [ats_pkg::MOD_W-1:0]         w_du, w_dv, w_rem_u, w_rem_v;
    logic [ats_pkg::DVD_W-1:0]         w_au, w_av;
    logic signed [S_W-1:0]             w_su, w_sv;
    logic [ats_pkg::DIM_W-1:0]         w_col, w_row;
    logic [ats_pkg::CNT_W-1:0]         w_count;

    function automatic logic signed [ats_pkg::ACC_W-1:0] f_sat(
        input logic signed [S_W-2:0] v
    );
        logic hi_ok;
        hi_ok = (v[S_W-2:ats_pkg::ACC_W-1] == '0) || (v[S_W-2:ats_pkg::ACC_W-1] == '1);
        if (hi_ok) begin
            return v[ats_pkg::ACC_W-1:0];
        end
        return v[S_W-2] ? {1'b1, {(ats_pkg::ACC_W-1){1'b0}}}
                        : {1'b0, {(ats_pkg::ACC_W-1){1'b1}}};
    endfunction

    function automatic logic [ats_pkg::DVD_W-1:0] f_mag(
        input logic signed [ats_pkg::ACC_W-1:0] c
    );
        logic signed [ats_pkg::ACC_W:0] cr;
        logic signed [ats_pkg::ACC_W-ats_pkg::FRAC_W:0] r;
        cr = (ats_pkg::ACC_W+1)'(c) + (ats_pkg::ACC_W+1)'(1 << (ats_pkg::FRAC_W - 1));
        r  = cr[ats_pkg::ACC_W:ats_pkg::FRAC_W];
        return r[ats_pkg::ACC_W-ats_pkg::FRAC_W] ? ats_pkg::DVD_W'(-r)
                                                 : ats_pkg::DVD_W'(r);
    endfunction

    function automatic logic [ats_pkg::DIM_W-1:0] f_tile(
        input logic signed [ats_pkg::ACC_W-1:0] c,
        input logic [ats_pkg::MOD_W-1:0]        m,
        input logic [ats_pkg::SIZE_W-1:0]       s,
        input logic [1:0]                       mode
    );
        logic [ats_pkg::DVD_W-1:0]  fl;
        logic [ats_pkg::SIZE_W-1:0] rp;
        logic [ats_pkg::MOD_W-1:0]  mr;
        logic [ats_pkg::DIM_W-1:0]  res;
        fl = c[ats_pkg::ACC_W-1:ats_pkg::FRAC_W];
        rp = s - m[ats_pkg::SIZE_W-1:0] - 1'b1;
        mr = {s, 1'b0} - m - 1'b1;
        case (mode)
            ats_pkg::TILE_REPEAT: res = c[ats_pkg::ACC_W-1] ? rp[ats_pkg::DIM_W-1:0]
                                                            : m[ats_pkg::DIM_W-1:0];
            ats_pkg::TILE_MIRROR: res = (m >= {1'b0, s}) ? mr[ats_pkg::DIM_W-1:0]
                                                         : m[ats_pkg::DIM_W-1:0];
            default: begin
                if (c[ats_pkg::ACC_W-1]) begin
                    res = '0;
                end else if (fl >= ats_pkg::DVD_W'(s)) begin
                    rp  = s - 1'b1;
                    res = rp[ats_pkg::DIM_W-1:0];
                end else begin
                    res = fl[ats_pkg::DIM_W-1:0];
                end
            end
        endcase
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_xx <= 32'sd65536;
            r_m_yx <= '0;
            r_m_xy <= '0;
            r_m_yy <= 32'sd65536;
            r_m_tx <= '0;
            r_m_ty <= '0;
            r_tile <= ats_pkg::TILE_CLAMP;
            r_size <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (ats_pkg::t_cfg_idx'(i_cfg_index))
                ats_pkg::CFG_M_XX: r_m_xx <= i_cfg_wdata;
                ats_pkg::CFG_M_YX: r_m_yx <= i_cfg_wdata;
                ats_pkg::CFG_M_XY: r_m_xy <= i_cfg_wdata;
                ats_pkg::CFG_M_YY: r_m_yy <= i_cfg_wdata;
                ats_pkg::CFG_M_TX: r_m_tx <= i_cfg_wdata;
                ats_pkg::CFG_M_TY: r_m_ty <= i_cfg_wdata;
                ats_pkg::CFG_TILE: r_tile <= i_cfg_wdata[1:0];
                ats_pkg::CFG_SIZE: r_size <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_count = (i_span_count > ats_pkg::CNT_W'(ats_pkg::SPAN_MAX))
                   ? ats_pkg::CNT_W'(ats_pkg::SPAN_MAX) : i_span_count;
    assign w_sw = ats_pkg::SIZE_W'(r_size[7:0]) + 1'b1;
    assign w_sh = ats_pkg::SIZE_W'(r_size[15:8]) + 1'b1;
    assign w_du = (r_tile == ats_pkg::TILE_MIRROR) ? {w_sw, 1'b0} : {1'b0, w_sw};
    assign w_dv = (r_tile == ats_pkg::TILE_MIRROR) ? {w_sh, 1'b0} : {1'b0, w_sh};
    assign w_au = f_mag(r_u);
    assign w_av = f_mag(r_v);
    assign w_su = S_W'(r_p_uxx) + S_W'(r_p_uxy) + S_W'($signed({r_m_tx, 1'b0}));
    assign w_sv = S_W'(r_p_vyx) + S_W'(r_p_vyy) + S_W'($signed({r_m_ty, 1'b0}));
    assign w_col = f_tile(r_u, w_rem_u, w_sw, r_tile);
    assign w_row = f_tile(r_v, w_rem_v, w_sh, r_tile);

    ats_mod u_mod_u (
        .i_clk      (i_clk),
        .i_start    (i_cmd.prep),
        .i_step     (i_cmd.div),
        .i_dividend (w_au),
        .i_divisor  (w_du),
        .o_rem      (w_rem_u)
    );

    ats_mod u_mod_v (
        .i_clk      (i_clk),
        .i_start    (i_cmd.prep),
        .i_step     (i_cmd.div),
        .i_dividend (w_av),
        .i_divisor  (w_dv),
        .o_rem      (w_rem_v)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[{i_tex_row, i_tex_col}] <= i_texel;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_mem[{w_row, w_col}];
            r_rd_last <= (r_left == ats_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_x2 <= {i_dev_x, 1'b1};
            r_y2 <= {i_dev_y, 1'b1};
        end
        if (i_cmd.mul) begin
            r_p_uxx <= r_m_xx * r_x2;
            r_p_uxy <= r_m_xy * r_y2;
            r_p_vyx <= r_m_yx * r_x2;
            r_p_vyy <= r_m_yy * r_y2;
        end
        if (i_cmd.push) begin
            r_out_data <= r_rd_data;
            r_out_last <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u         <= '0;
            r_v         <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_left <= w_count;
            end
            if (i_cmd.sum) begin
                r_u <= f_sat(w_su[S_W-1:1]);
                r_v <= f_sat(w_sv[S_W-1:1]);
            end
            if (i_cmd.push) begin
                r_left      <= r_left - 1'b1;
                r_u         <= f_sat((S_W-1)'(r_u) + (S_W-1)'(r_m_xx));
                r_v         <= f_sat((S_W-1)'(r_v) + (S_W-1)'(r_m_yx));
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last        = (r_left == ats_pkg::CNT_W'(1));
    assign o_sts.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_pixel           = r_out_data;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd)) else $error("datapath commands overlap");
    a_push_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_left != '0) else $error("push with no pixel left");
    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && o_sts.last |=> r_left == '0 && r_out_last)
        else $error("last pixel not marked");
`endif

endmodule

// ----- hdl/affine_texture_sampler_tiled.sv -----
// ----------------------------------------------------------------------------
// affine_texture_sampler_tiled
// Nearest-neighbor texture sampler with affine mapping and tiling.
// ----------------------------------------------------------------------------
// Input stream: tuser is the opcode. A load word writes one texel into the
// 256 x 256 store in the cycle it is accepted; the store needs no clearing.
// A span word maps each pixel center through the Q16.16 matrix, tiles it
// by clamp, repeat or mirror and emits one output word per pixel, tlast on
// the final one. Configuration writes must be taken only while the block
// is idle; the block itself does not enforce this. A span runs the set-up
// steps (accept, products, sum), then per pixel a remainder set-up, the
// radix-16 remainder unit, one store read and one push into the output
// register. s_axis_tready is high only between spans, so a new item is
// taken while the last pixel still waits in the output register.
// Reset returns the sequencer to idle, empties the output register and
// restores the matrix to identity, clamp mode and a 256 x 256 texture.
// A stalled receiver holds the output word and the sequencer stops at the
// push step until it is taken.
// ----------------------------------------------------------------------------
module affine_texture_sampler_tiled (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dev_x, dev_y, span_count, tex_col, tex_row, texel, zero fill
    input  logic [ats_pkg::IN_W-1:0]        s_axis_tdata,
    // opcode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel
    output logic [ats_pkg::TEXEL_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [ats_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [ats_pkg::CFG_W-1:0]       i_cfg_wdata
);

    ats_pkg::t_cmd w_cmd;
    ats_pkg::t_sts w_sts;

    ats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .i_count_nz (s_axis_tdata[38:32] != '0),
        .i_sts      (w_sts),
        .o_ready    (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    ats_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_dev_x      (s_axis_tdata[15:0]),
        .i_dev_y      (s_axis_tdata[31:16]),
        .i_span_count (s_axis_tdata[38:32]),
        .i_tex_col    (s_axis_tdata[46:39]),
        .i_tex_row    (s_axis_tdata[54:47]),
        .i_texel      (s_axis_tdata[86:55]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_pixel      (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tiled affine texture sampler: loads texels,
// shades spans under several matrices, tile modes and sizes, and compares
// every output word with a built-in predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 20000;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [ats_pkg::IN_W-1:0]          s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [ats_pkg::TEXEL_W-1:0]       m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              i_cfg_we;
    logic [ats_pkg::CIDX_W-1:0]        i_cfg_index;
    logic [ats_pkg::CFG_W-1:0]         i_cfg_wdata;

    affine_texture_sampler_tiled dut (.*);

    typedef struct {
        ats_pkg::t_op op;
        logic [15:0]  dx;
        logic [15:0]  dy;
        logic [6:0]   cnt;
        logic [7:0]   col;
        logic [7:0]   row;
        logic [31:0]  tx;
    } t_word;

    typedef struct {
        logic [31:0] pix;
        logic        lst;
    } t_pix;

    logic [31:0]        tex_mem [0:65535];
    logic signed [63:0] mat [0:5];
    ats_pkg::t_tile     mode_q;
    logic [15:0]        size_q;
    t_pix               pix_fifo[$];
    int                 errors;
    int                 idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] fl_shr(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] sat_acc(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic logic signed [63:0] wrap_coord(logic signed [63:0] c,
                                                      logic signed [63:0] sz);
        logic signed [63:0] r, t, a;
        r = fl_shr(c + 64'sd32768, 16);
        case (mode_q)
            ats_pkg::TILE_REPEAT: begin
                if (c < 0) begin
                    a = r < 0 ? -r : r;
                    return sz - (a % sz) - 1;
                end
                return r % sz;
            end
            ats_pkg::TILE_MIRROR: begin
                t = r % (2 * sz);
                if (t < 0) t = -t;
                if (t >= sz) t = 2 * sz - t - 1;
                return t;
            end
            default: begin
                if (c < 0) return 0;
                t = fl_shr(c, 16);
                return t >= sz ? sz - 1 : t;
            end
        endcase
    endfunction

    function automatic void sample_span(t_word w);
        logic signed [63:0] x2, y2, u, v, wd, ht, cu, cv;
        int n;
        t_pix p;
        x2 = 2 * $signed({{48{w.dx[15]}}, w.dx}) + 1;
        y2 = 2 * $signed({{48{w.dy[15]}}, w.dy}) + 1;
        n  = (w.cnt > ats_pkg::SPAN_MAX) ? ats_pkg::SPAN_MAX : int'(w.cnt);
        wd = 64'(size_q[7:0]) + 64'sd1;
        ht = 64'(size_q[15:8]) + 64'sd1;
        u  = sat_acc(fl_shr(mat[0] * x2 + mat[2] * y2 + 2 * mat[4], 1));
        v  = sat_acc(fl_shr(mat[1] * x2 + mat[3] * y2 + 2 * mat[5], 1));
        for (int i = n; i > 0; i--) begin
            cu = wrap_coord(u, wd);
            cv = wrap_coord(v, ht);
            p.pix = tex_mem[16'(cv * 256 + cu)];
            p.lst = (i == 1);
            pix_fifo.push_back(p);
            u = sat_acc(u + mat[0]);
            v = sat_acc(v + mat[1]);
        end
    endfunction

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_write(ats_pkg::t_cfg_idx idx, logic [31:0] val);
        drop_valid();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx <= ats_pkg::CFG_M_TY) mat[idx] = $signed(val);
        else if (idx == ats_pkg::CFG_TILE) mode_q = ats_pkg::t_tile'(val[1:0]);
        else size_q = val[15:0];
    endtask

    // Hold tvalid across back-to-back words; drop it only for a gap.
    task automatic send_word(t_word w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= {1'b0, w.tx, w.row, w.col, w.cnt, w.dy, w.dx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (w.op == ats_pkg::OP_LOAD) begin
            tex_mem[{w.row, w.col}] = w.tx;
        end else begin
            sample_span(w);
        end
    endtask

    task automatic wait_idle();
        drop_valid();
        while (pix_fifo.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Span whose every pixel hits a texel already written.
    function automatic t_word rand_span(int maxn);
        t_word w;
        w.op  = ats_pkg::OP_SPAN;
        w.dx  = 16'($urandom);
        w.dy  = 16'($urandom);
        w.cnt = 7'($urandom_range(1, maxn));
        w.col = 8'($urandom);
        w.row = 8'($urandom);
        w.tx  = $urandom;
        return w;
    endfunction

    task automatic load_all(int w, int h);
        t_word l;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                l = '{ats_pkg::OP_LOAD, 16'($urandom), 16'($urandom), 7'($urandom),
                      8'(c), 8'(r), 32'($urandom)};
                send_word(l);
            end
    endtask

    // Directed rows: opcode, dev_x, dev_y, count, col, row, texel.
    t_word dir_rows [0:9] = '{
        '{ats_pkg::OP_LOAD, 16'h0000, 16'h0000, 7'd0,   8'd0,   8'd0,   32'hFFFF_FFFF},
        '{ats_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 7'd127, 8'd1,   8'd0,   32'h0000_0000},
        '{ats_pkg::OP_LOAD, 16'h0000, 16'h0000, 7'd0,   8'd0,   8'd1,   32'hA5A5_5A5A},
        '{ats_pkg::OP_LOAD, 16'h0000, 16'h0000, 7'd0,   8'd1,   8'd1,   32'h1234_5678},
        '{ats_pkg::OP_SPAN, 16'h8000, 16'h8000, 7'd1,   8'd0,   8'd0,   32'h0},
        '{ats_pkg::OP_SPAN, 16'h7FFF, 16'h7FFF, 7'd64,  8'd255, 8'd255, 32'h0},
        '{ats_pkg::OP_SPAN, 16'hFFFE, 16'h0000, 7'd127, 8'd0,   8'd0,   32'h0},
        '{ats_pkg::OP_SPAN, 16'h0000, 16'hFFFF, 7'd0,   8'd0,   8'd0,   32'h0},
        '{ats_pkg::OP_SPAN, 16'h0001, 16'h0001, 7'd5,   8'd0,   8'd0,   32'h0},
        '{ats_pkg::OP_SPAN, 16'h0000, 16'h0000, 7'd3,   8'd0,   8'd0,   32'h0}
    };

    initial begin
        t_word w;
        logic [31:0] cf;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= ats_pkg::CFG_M_XX;
        i_cfg_wdata   <= '0;
        errors = 0;
        mat = '{64'sd65536, 64'sd0, 64'sd0, 64'sd65536, 64'sd0, 64'sd0};
        mode_q = ats_pkg::TILE_CLAMP;
        size_q = 16'hFFFF;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Shrink to 2x2 so every sample lands on a loaded texel.
        cfg_write(ats_pkg::CFG_SIZE, 32'h0000_0101);
        for (int i = 0; i < 10; i++) begin
            send_word(dir_rows[i]);
            if (i == 4) begin
                wait_idle();
                cfg_write(ats_pkg::CFG_TILE, 32'(ats_pkg::TILE_REPEAT));
            end
            if (i == 6) begin
                wait_idle();
                cfg_write(ats_pkg::CFG_TILE, 32'(ats_pkg::TILE_MIRROR));
            end
            if (i == 8) begin
                wait_idle();
                cfg_write(ats_pkg::CFG_TILE, 32'(ats_pkg::TILE_SPARE));
            end
        end
        wait_idle();

        // Random phases; texture small and fully loaded before spans.
        for (int ph = 0; ph < 12; ph++) begin
            int wd, ht;
            wait_idle();
            wd = (ph % 3 == 0) ? 1 : int'($urandom_range(1, 8));
            ht = (ph % 4 == 1) ? 1 : int'($urandom_range(1, 8));
            cfg_write(ats_pkg::CFG_SIZE, 32'(((ht - 1) << 8) | (wd - 1)));
            for (int k = 0; k < 6; k++) begin
                case ($urandom_range(0, 3))
                    0: cf = 32'h8000_0000;
                    1: cf = 32'h7FFF_FFFF;
                    2: cf = $urandom_range(0, 1) ? 32'($urandom_range(0, 262144))
                                                 : -32'($urandom_range(0, 262144));
                    default: cf = $urandom;
                endcase
                cfg_write(ats_pkg::t_cfg_idx'(k), cf);
            end
            cfg_write(ats_pkg::CFG_TILE, 32'($urandom_range(0, 3)));
            load_all(wd, ht);
            for (int k = 0; k < 10; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    w = rand_span(1);
                    w.op = ats_pkg::OP_LOAD;
                    w.col = 8'($urandom_range(0, wd - 1));
                    w.row = 8'($urandom_range(0, ht - 1));
                end else begin
                    w = rand_span($urandom_range(0, 7) == 0 ? 127 : 12);
                end
                send_word(w);
            end
        end
        wait_idle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    int rdy_wait;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rdy_wait = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (pix_fifo.size() == 0) begin
                $display("%0t unexpected word: actual %h/%b", $realtime,
                         m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                t_pix e;
                e = pix_fifo.pop_front();
                if (e.pix !== m_axis_tdata || e.lst !== m_axis_tlast) begin
                    $display("%0t mismatch: expected %h/%b actual %h/%b", $realtime,
                             e.pix, e.lst, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
            rdy_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
            m_axis_tready <= (rdy_wait == 0);
        end else if (rdy_wait > 0) begin
            rdy_wait--;
            m_axis_tready <= (rdy_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end
endmodule
